>>> hdl/pmp_pkg.sv
// ----------------------------------------------------------------------------
// PMP check package
// Shared constants, command codes and the request type for the PMP check core.
// ----------------------------------------------------------------------------
package pmp_pkg;

    localparam int MaxEntries = 64;
    localparam int IdxW       = 6;

    localparam logic [1:0] CMD_CHECK = 2'd0;
    localparam logic [1:0] CMD_WCFG  = 2'd1;
    localparam logic [1:0] CMD_WADDR = 2'd2;
    localparam logic [1:0] CMD_RSVD  = 2'd3;

    localparam logic [1:0] PRIV_U    = 2'd0;
    localparam logic [1:0] PRIV_S    = 2'd1;
    localparam logic [1:0] PRIV_M    = 2'd2;
    localparam logic [1:0] PRIV_RSVD = 2'd3;

    localparam logic [1:0] KIND_R    = 2'd0;
    localparam logic [1:0] KIND_W    = 2'd1;
    localparam logic [1:0] KIND_X    = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    localparam logic [1:0] MODE_TOR   = 2'd1;
    localparam logic [1:0] MODE_NA4   = 2'd2;
    localparam logic [1:0] MODE_NAPOT = 2'd3;

    // Request as it travels from the front to the back part.
    typedef struct packed {
        logic [1:0]      cmd;
        logic [IdxW-1:0] idx;
        logic [31:0]     data;
        logic [31:0]     word;
        logic [1:0]      priv;
        logic [1:0]      kind;
    } t_req;

    // Result of one request.
    typedef struct packed {
        logic            fault;
        logic            matched;
        logic [IdxW-1:0] index;
    } t_res;

endpackage

>>> hdl/pmp_front.sv
// ----------------------------------------------------------------------------
// PMP front part
// Accepts requests and holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module pmp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  pmp_pkg::t_req i_req,
    output logic          o_valid,
    output pmp_pkg::t_req o_req,
    input  logic          i_take
);

    // Two-entry queue.
    pmp_pkg::t_req r_q [2];
    logic          r_rd;
    logic          r_wr;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          w_push;
    logic          w_take;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_take  = i_take && o_valid;

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wr <= !r_wr;
            if (w_take) r_rd <= !r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wr] <= i_req;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("front queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_rd == r_wr))
        else $error("front queue pointers disagree when empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_rd == r_wr))
        else $error("front queue pointers disagree when full");

endmodule

>>> hdl/pmp_back.sv
// ----------------------------------------------------------------------------
// PMP back part
// Holds the entry table and walks it one entry a cycle for each check.
// ----------------------------------------------------------------------------
module pmp_back #(
    parameter int ENTRIES = pmp_pkg::MaxEntries
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  pmp_pkg::t_req i_req,
    output logic          o_take,
    output logic          o_empty,
    input  logic          i_pop,
    output pmp_pkg::t_res o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [pmp_pkg::IdxW-1:0] Last = pmp_pkg::IdxW'(ENTRIES - 1);

    // Entry table; per-entry valid bits stand for the zero reset value.
    logic [7:0]   r_cfg  [pmp_pkg::MaxEntries];
    logic [31:0]  r_addr [pmp_pkg::MaxEntries];
    logic [pmp_pkg::MaxEntries-1:0] r_cfg_vld;
    logic [pmp_pkg::MaxEntries-1:0] r_addr_vld;
    logic [7:0]   r_cfg_rd;
    logic [31:0]  r_addr_rd;

    logic [1:0]               r_state;
    pmp_pkg::t_req            r_req;
    logic [pmp_pkg::IdxW-1:0] r_i;
    logic [pmp_pkg::IdxW-1:0] n_i;
    logic [31:0]              r_lower;
    pmp_pkg::t_res            r_acc;
    pmp_pkg::t_res            r_res;
    logic                     r_full;

    logic [7:0]  w_cfg;
    logic [31:0] w_a;
    logic [31:0] w_mask;
    logic        w_hit;
    logic        w_grant;
    logic        w_take;
    logic        w_fault;
    logic        w_post;
    logic        w_wr_cfg;
    logic        w_wr_addr;

    assign o_empty   = !r_full;
    assign o_res     = r_res;
    assign w_take    = i_valid && (r_state == ST_IDLE);
    assign o_take    = w_take;
    assign w_post    = (r_state == ST_DONE) && (!r_full || i_pop);
    assign w_wr_cfg  = i_rst_n && w_take && (i_req.cmd == pmp_pkg::CMD_WCFG) &&
                       (int'(i_req.idx) < ENTRIES);
    assign w_wr_addr = i_rst_n && w_take && (i_req.cmd == pmp_pkg::CMD_WADDR) &&
                       (int'(i_req.idx) < ENTRIES);

    // Entry to be presented by the table read in the next cycle.
    always_comb begin
        n_i = r_i;
        if (w_take) begin
            n_i = '0;
        end else if (r_state == ST_SCAN && !w_hit && r_i != Last) begin
            n_i = r_i + 1'b1;
        end
    end

    // Table writes and the registered read of the entry under scan.
    always_ff @(posedge i_clk) begin
        if (w_wr_cfg) r_cfg[i_req.idx] <= i_req.data[7:0];
        if (w_wr_addr) r_addr[i_req.idx] <= i_req.data;
        r_cfg_rd  <= r_cfg[n_i];
        r_addr_rd <= r_addr[n_i];
    end

    // Current entry under scan.
    always_comb begin
        w_cfg = r_cfg_vld[r_i] ? r_cfg_rd : 8'd0;
        w_a   = r_addr_vld[r_i] ? r_addr_rd : 32'd0;
    end

    // NAPOT mask: ones over the trailing ones and one bit more.
    always_comb begin
        w_mask = {w_a[30:0], 1'b1} & ~({w_a[30:0], 1'b1} + 32'd1);
        w_mask = w_mask | (w_mask - 32'd1);
        if (&w_a[30:0]) w_mask = 32'hFFFF_FFFF;
    end

    always_comb begin
        unique case (w_cfg[4:3])
            pmp_pkg::MODE_TOR:   w_hit = (r_req.word >= r_lower) && (r_req.word < w_a);
            pmp_pkg::MODE_NA4:   w_hit = (r_req.word == w_a);
            pmp_pkg::MODE_NAPOT: w_hit = ((r_req.word ^ w_a) & ~w_mask) == 32'd0;
            default:             w_hit = 1'b0;
        endcase
        case (r_req.kind)
            pmp_pkg::KIND_R: w_grant = w_cfg[0];
            pmp_pkg::KIND_W: w_grant = w_cfg[1];
            pmp_pkg::KIND_X: w_grant = w_cfg[2];
            default:         w_grant = 1'b0;
        endcase
        w_fault = !((r_req.priv == pmp_pkg::PRIV_M && !w_cfg[7]) || w_grant);
    end

    // Valid bits, the scan sequencer and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_full     <= 1'b0;
            r_i        <= '0;
            r_cfg_vld  <= '0;
            r_addr_vld <= '0;
        end else begin
            r_i <= n_i;
            if (w_wr_cfg) r_cfg_vld[i_req.idx] <= 1'b1;
            if (w_wr_addr) r_addr_vld[i_req.idx] <= 1'b1;
            if (w_post) begin
                r_full <= 1'b1;
            end else if (i_pop && r_full) begin
                r_full <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_req   <= i_req;
                        r_lower <= 32'd0;
                        r_acc   <= '0;
                        if (i_req.cmd == pmp_pkg::CMD_CHECK) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_acc.fault   <= w_fault;
                        r_acc.matched <= 1'b1;
                        r_acc.index   <= r_i;
                        r_state       <= ST_DONE;
                    end else if (r_i == Last) begin
                        r_acc.fault <= (r_req.priv != pmp_pkg::PRIV_M);
                        r_state     <= ST_DONE;
                    end else begin
                        r_lower <= w_a;
                    end
                end
                ST_DONE: begin
                    if (w_post) begin
                        r_res   <= r_acc;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_req.cmd == pmp_pkg::CMD_CHECK))
        else $error("scan running for a write request");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !r_res.matched) |-> (r_res.index == '0))
        else $error("index set without a match");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (r_state != ST_IDLE))
        else $error("accepted request did not start");

endmodule

>>> hdl/pmp_access_check_core.sv
// ----------------------------------------------------------------------------
// PMP access check core
// Physical memory protection table with check, config write and address
// write requests.
// ----------------------------------------------------------------------------
// Usage: requests enter through i_push/o_full; a request is taken on a clock
// edge with i_push high and o_full low. Results leave through o_empty/i_pop;
// the oldest result is on o_fault, o_matched and o_match_index while o_empty
// is low and leaves on an edge with i_pop high.
// A two-deep queue in the front part feeds the back part. The back part
// takes a request from the queue only while idle and walks the entry
// table one entry a cycle. A check that matches ends its scan at the first
// matching entry, a check without a match scans to the last entry, and a
// write skips the scan. The back part takes no new request until it has
// posted its result, so the scan of the table sets the rate.
// Every request gives exactly one result (zeros for writes).
// After reset all entries read as off with a zero address, with no clearing
// pass. When the receiver stalls the result is held, the back part waits
// with the next result and the queue fills, after which o_full rises.
// ----------------------------------------------------------------------------
module pmp_access_check_core #(
    parameter int ENTRIES = pmp_pkg::MaxEntries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_entry_index,
    input  logic [31:0] i_write_data,
    input  logic [33:0] i_access_address,
    input  logic [1:0]  i_privilege,
    input  logic [1:0]  i_access_kind,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_fault,
    output logic        o_matched,
    output logic [5:0]  o_match_index
);

    pmp_pkg::t_req w_in;
    pmp_pkg::t_req w_q;
    pmp_pkg::t_res w_res;
    logic          w_valid;
    logic          w_take;

    // Pack the request; only the word address is kept.
    assign w_in = '{cmd: i_cmd, idx: i_entry_index, data: i_write_data,
                    word: i_access_address[33:2], priv: i_privilege,
                    kind: i_access_kind};

    pmp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_req(w_in), .o_valid(w_valid), .o_req(w_q), .i_take(w_take)
    );

    pmp_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_req(w_q),
        .o_take(w_take), .o_empty(o_empty), .i_pop(i_pop), .o_res(w_res)
    );

    assign o_fault       = w_res.fault;
    assign o_matched     = w_res.matched;
    assign o_match_index = w_res.index;

endmodule
